// ===== rtl/tcal_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch calibration solver package
// Shared types, widths, target tables and constant helpers.
// ----------------------------------------------------------------------------
package tcal_pkg;

  // Field and accumulator widths.
  localparam int RAW_W  = 12;
  localparam int SPAN_W = 12;
  localparam int CAL_W  = 16;
  localparam int SR_W   = 16;
  localparam int SRR_W  = 27;
  localparam int SRS_W  = 24;
  localparam int SS_W   = 11;

  // Solver datapath widths.
  localparam int DEN_W  = 34;
  localparam int ANUM_W = 29;
  localparam int NUM_W  = 48;
  localparam int DVS_W  = 33;

  // Job queue depth.
  localparam int QDEPTH = 2;

  // Configuration register indexes.
  localparam logic CFG_X_SPAN = 1'b0;
  localparam logic CFG_Y_SPAN = 1'b1;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_t;

  typedef struct packed {
    logic signed [CAL_W-1:0] cal_x_min;
    logic signed [CAL_W-1:0] cal_x_max;
    logic signed [CAL_W-1:0] cal_y_min;
    logic signed [CAL_W-1:0] cal_y_max;
    logic                    fit_ok;
  } out_t;

  // Sums that feed one axis fit.
  typedef struct packed {
    logic [SR_W-1:0]  sr;
    logic [SRR_W-1:0] srr;
    logic [SRS_W-1:0] srs;
  } axis_sums_t;

  // One complete calibration job: x fit uses raw y, y fit uses raw x.
  typedef struct packed {
    axis_sums_t fx;
    axis_sums_t fy;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  // Screen x target for a point; later points use the fixed target 120.
  function automatic logic [7:0] tgt_x_f(input logic [3:0] idx);
    case (idx)
      4'd0:    tgt_x_f = 8'd36;
      4'd1:    tgt_x_f = 8'd204;
      4'd2:    tgt_x_f = 8'd36;
      4'd3:    tgt_x_f = 8'd204;
      default: tgt_x_f = 8'd120;
    endcase
  endfunction

  // Screen y target for a point; later points use the fixed target 214.
  function automatic logic [8:0] tgt_y_f(input logic [3:0] idx);
    case (idx)
      4'd0:    tgt_y_f = 9'd148;
      4'd1:    tgt_y_f = 9'd148;
      4'd2:    tgt_y_f = 9'd280;
      4'd3:    tgt_y_f = 9'd280;
      default: tgt_y_f = 9'd214;
    endcase
  endfunction

  // Sum of the screen x targets over the first n points.
  function automatic logic [SS_W-1:0] ss_x_f(input int n);
    logic [SS_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      acc = acc + SS_W'(tgt_x_f(4'(k)));
    end
    return acc;
  endfunction

  // Sum of the screen y targets over the first n points.
  function automatic logic [SS_W-1:0] ss_y_f(input int n);
    logic [SS_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      acc = acc + SS_W'(tgt_y_f(4'(k)));
    end
    return acc;
  endfunction

endpackage

// ===== rtl/tcal_fifo.sv =====
// ----------------------------------------------------------------------------
// Touch calibration job queue
// Small register queue that decouples sample intake from the solver.
// ----------------------------------------------------------------------------
module tcal_fifo import tcal_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  input  logic pop_i,
  output job_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  job_t                 mem_q [QDEPTH];
  logic [PTR_W-1:0]     wptr_q, rptr_q;
  logic [PTR_W:0]       cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(QDEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(QDEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tcal_div.sv =====
// ----------------------------------------------------------------------------
// Touch calibration serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcal_div import tcal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DVS_W:0]   rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  // Trial subtraction for the next quotient bit.
  assign shifted = {rem_q[DVS_W-1:0], quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        if (!diff[DVS_W]) begin
          rem_q <= diff;
          quo_q <= {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted;
          quo_q <= {quo_q[NUM_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tcal_front.sv =====
// ----------------------------------------------------------------------------
// Touch calibration sample front end
// Accumulates the per-point sums and hands finished jobs to the queue.
// ----------------------------------------------------------------------------
module tcal_front import tcal_pkg::*; #(
  parameter int NUM_POINTS = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_data_i,
  output logic in_ready_o,
  output logic push_o,
  output job_t job_o,
  input  logic full_i
);

  localparam int CNT_W = (NUM_POINTS > 2) ? $clog2(NUM_POINTS) : 1;

  logic [CNT_W-1:0] cnt_q;
  job_t             sums_q;
  job_t             sums_next;
  logic             last, accept;
  logic [7:0]       tx;
  logic [8:0]       ty;

  assign tx     = tgt_x_f(4'(cnt_q));
  assign ty     = tgt_y_f(4'(cnt_q));
  assign last   = (cnt_q == CNT_W'(NUM_POINTS - 1));
  assign accept = in_valid_i && in_ready_o;

  // The last sample of a set waits only while the queue is full.
  assign in_ready_o = !(last && full_i);
  assign push_o     = accept && last;
  assign job_o      = sums_next;

  // Running sums with the current sample folded in, wrapped to width.
  always_comb begin
    sums_next.fx.sr  = sums_q.fx.sr + SR_W'(in_data_i.raw_y);
    sums_next.fx.srr = sums_q.fx.srr + SRR_W'(24'(in_data_i.raw_y) * 24'(in_data_i.raw_y));
    sums_next.fx.srs = sums_q.fx.srs + SRS_W'(20'(in_data_i.raw_y) * 20'(tx));
    sums_next.fy.sr  = sums_q.fy.sr + SR_W'(in_data_i.raw_x);
    sums_next.fy.srr = sums_q.fy.srr + SRR_W'(24'(in_data_i.raw_x) * 24'(in_data_i.raw_x));
    sums_next.fy.srs = sums_q.fy.srs + SRS_W'(21'(in_data_i.raw_x) * 21'(ty));
  end

  // Point counter and accumulators; both restart after the last point.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sums_q <= '0;
    end else if (accept) begin
      if (last) begin
        cnt_q  <= '0;
        sums_q <= '0;
      end else begin
        cnt_q  <= cnt_q + 1'b1;
        sums_q <= sums_next;
      end
    end
  end

endmodule

// ===== rtl/tcal_back.sv =====
// ----------------------------------------------------------------------------
// Touch calibration solver back end
// Sequences both axis fits through one serial divider.
// ----------------------------------------------------------------------------
module tcal_back import tcal_pkg::*; #(
  parameter int NUM_POINTS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  input  logic [SPAN_W-1:0] x_span_i,
  input  logic [SPAN_W-1:0] y_span_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o
);

  localparam logic [3:0]      NP   = 4'(NUM_POINTS);
  localparam logic [SS_W-1:0] SS_X = ss_x_f(NUM_POINTS);
  localparam logic [SS_W-1:0] SS_Y = ss_y_f(NUM_POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DEN1, S_DEN2, S_AN1, S_AN2, S_CHK, S_ZN,
    S_DST, S_DWAIT, S_EN1, S_EN2, S_NEXT
  } state_e;

  state_e                   state_q;
  job_t                     job_q;
  logic                     axis_q, edge_q, ok_q, neg_q, start_q;
  logic [31:0]              p_q;
  logic signed [DEN_W-1:0]  den_q;
  logic signed [ANUM_W-1:0] anum_q;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [DVS_W-1:0]  dvs_q;
  logic signed [CAL_W-1:0]  zero_q;
  logic signed [CAL_W-1:0]  xmin_q, xmax_q, ymin_q, ymax_q;
  out_t                     out_q;
  logic                     out_valid_q;

  axis_sums_t        cur;
  logic [SS_W-1:0]   ss;
  logic [SPAN_W-1:0] span;
  logic [30:0]       nsrr;
  logic [27:0]       nsrs;
  logic signed [CAL_W-1:0] sat_val;
  div_req_t          dreq;
  div_rsp_t          drsp;

  // Operands of the axis being solved.
  assign cur  = axis_q ? job_q.fy : job_q.fx;
  assign ss   = axis_q ? SS_Y : SS_X;
  assign span = axis_q ? y_span_i : x_span_i;
  assign nsrr = 31'(cur.srr) * 31'(NP);
  assign nsrs = 28'(cur.srs) * 28'(NP);

  assign pop_o       = (state_q == S_IDLE) && !empty_i && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Divider request from the held numerator and divisor magnitudes.
  assign dreq.start    = start_q;
  assign dreq.dividend = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign dreq.divisor  = dvs_q[DVS_W-1] ? DVS_W'(-dvs_q) : DVS_W'(dvs_q);

  tcal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // Apply the quotient sign and saturate to 16 bits.
  always_comb begin
    if (neg_q) begin
      if (drsp.quotient > NUM_W'(32768)) begin
        sat_val = -16'sd32768;
      end else begin
        sat_val = CAL_W'(-drsp.quotient);
      end
    end else begin
      if (drsp.quotient > NUM_W'(32767)) begin
        sat_val = 16'sd32767;
      end else begin
        sat_val = CAL_W'(drsp.quotient);
      end
    end
  end

  // Solver sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
      axis_q      <= 1'b0;
      edge_q      <= 1'b0;
      ok_q        <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            job_q   <= job_i;
            axis_q  <= 1'b0;
            ok_q    <= 1'b1;
            state_q <= S_DEN1;
          end
        end
        S_DEN1: begin
          p_q     <= 32'(cur.sr) * 32'(cur.sr);
          state_q <= S_DEN2;
        end
        S_DEN2: begin
          den_q   <= $signed(DEN_W'(nsrr)) - $signed(DEN_W'(p_q));
          state_q <= S_AN1;
        end
        S_AN1: begin
          p_q     <= 32'(cur.sr) * 32'(ss);
          state_q <= S_AN2;
        end
        S_AN2: begin
          anum_q  <= $signed(ANUM_W'(nsrs)) - $signed(ANUM_W'(p_q[26:0]));
          state_q <= S_CHK;
        end
        S_CHK: begin
          // A flat axis or a zero slope fails the fit.
          if (den_q == '0 || anum_q == '0) begin
            ok_q    <= 1'b0;
            state_q <= S_NEXT;
          end else begin
            num_q   <= NUM_W'($signed({1'b0, cur.sr}) * anum_q);
            state_q <= S_ZN;
          end
        end
        S_ZN: begin
          num_q   <= num_q - NUM_W'($signed({1'b0, ss}) * den_q);
          dvs_q   <= DVS_W'($signed({1'b0, NP}) * anum_q);
          edge_q  <= 1'b0;
          state_q <= S_DST;
        end
        S_DST: begin
          start_q <= 1'b1;
          neg_q   <= num_q[NUM_W-1] ^ dvs_q[DVS_W-1];
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (drsp.done) begin
            if (!edge_q) begin
              zero_q <= sat_val;
              if (axis_q) begin
                ymin_q <= sat_val;
              end else begin
                xmax_q <= sat_val;
              end
              state_q <= S_EN1;
            end else begin
              if (axis_q) begin
                ymax_q <= sat_val;
              end else begin
                xmin_q <= sat_val;
              end
              state_q <= S_NEXT;
            end
          end
        end
        S_EN1: begin
          num_q   <= NUM_W'(zero_q * anum_q);
          state_q <= S_EN2;
        end
        S_EN2: begin
          num_q   <= num_q + NUM_W'($signed({1'b0, span}) * den_q);
          dvs_q   <= DVS_W'(anum_q);
          edge_q  <= 1'b1;
          state_q <= S_DST;
        end
        S_NEXT: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= S_DEN1;
          end else begin
            out_q.fit_ok    <= ok_q;
            out_q.cal_x_min <= ok_q ? xmin_q : '0;
            out_q.cal_x_max <= ok_q ? xmax_q : '0;
            out_q.cal_y_min <= ok_q ? ymin_q : '0;
            out_q.cal_y_max <= ok_q ? ymax_q : '0;
            out_valid_q     <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/touch_calibration_lsq_solver.sv =====
// Flow: a sample that does not close a set is only accumulated; the closing sample
// yields its result after four serial divisions of 48 quotient bits each, two per
// axis; an axis whose fit fails skips its two divisions.
// Throughput: one sample per cycle, except a closing sample held by a full queue;
// the shared divider limits solved sets, with a two-job queue in between.
// Reset: asynchronous and active low; sums, counters and the queue clear at once
// and the span registers return to 239 and 319.
// ----------------------------------------------------------------------------
// Touch calibration least-squares solver
// Fits a line per axis from raw touch samples and emits panel limits.
// ----------------------------------------------------------------------------
module touch_calibration_lsq_solver import tcal_pkg::*; #(
  parameter int NUM_POINTS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [SPAN_W-1:0] cfg_wdata_i
);

  logic [SPAN_W-1:0] x_span_q, y_span_q;
  logic              push, pop, full, empty;
  job_t              wjob, rjob;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_span_q <= SPAN_W'(239);
      y_span_q <= SPAN_W'(319);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_SPAN: x_span_q <= cfg_wdata_i;
        CFG_Y_SPAN: y_span_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  tcal_front #(.NUM_POINTS(NUM_POINTS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .job_o      (wjob),
    .full_i     (full)
  );

  tcal_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .pop_i   (pop),
    .rdata_o (rjob),
    .full_o  (full),
    .empty_o (empty)
  );

  tcal_back #(.NUM_POINTS(NUM_POINTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (rjob),
    .pop_o       (pop),
    .x_span_i    (x_span_q),
    .y_span_i    (y_span_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/tcal_checker.sv =====
// ----------------------------------------------------------------------------
// Touch calibration port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tcal_checker import tcal_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // No result is offered while reset is applied.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // A stalled result transaction stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before acceptance");

  // A stalled result transaction keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // A failed fit reports all limits as zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.fit_ok |->
      (out_data_o.cal_x_min == '0) && (out_data_o.cal_x_max == '0) &&
      (out_data_o.cal_y_min == '0) && (out_data_o.cal_y_max == '0))
    else $error("failed fit with nonzero limits");

endmodule

bind touch_calibration_lsq_solver tcal_checker u_tcal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
